FILE: hw/rtl/rc4_variant_stream_cipher_assert.svh
`ifndef RC4_VARIANT_STREAM_CIPHER_ASSERT_SVH
`define RC4_VARIANT_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication, checked on clk_i, off while rst_ni is low
`define RC4V_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc4v check failed");

// next-cycle implication, checked on clk_i, off while rst_ni is low
`define RC4V_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc4v check failed");

`endif

FILE: hw/rtl/rc4v_pkg.sv
package rc4v_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_AW  = 9;
  localparam int unsigned MODE_W  = 2;

  // key store and permutation sizes
  localparam int unsigned KEY_DEPTH  = 512;
  localparam int unsigned PERM_DEPTH = 256;

  // command queue between front and engine
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // stream packing
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // input mode codes as they arrive on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_KEY    = 2'd0,
    MODE_SCHED  = 2'd1,
    MODE_CIPHER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // classified operations held in the queue
  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_SCHED  = 2'd1,
    OP_CIPHER = 2'd2
  } op_e;

  // result kinds
  localparam logic KIND_SCHED  = 1'b0;
  localparam logic KIND_CIPHER = 1'b1;

  typedef struct packed {
    op_e               op;
    logic [KEY_AW-1:0] key_addr;
    logic [BYTE_W-1:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic              key_ok;
  } result_t;

  // rotate a byte right by one bit
  function automatic logic [BYTE_W-1:0] rotr1(input logic [BYTE_W-1:0] v);
    rotr1 = {v[0], v[BYTE_W-1:1]};
  endfunction

endpackage

FILE: hw/rtl/rc4v_front.sv
module rc4v_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [rc4v_pkg::IN_DATA_W-1:0] s_data_i,   // key_addr, byte_value, zero pad
  input  logic [rc4v_pkg::MODE_W-1:0]   s_mode_i,
  output logic                          cmd_valid_o,
  output rc4v_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  rc4v_pkg::cmd_t              q_mem [rc4v_pkg::QUEUE_DEPTH];
  logic [rc4v_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [rc4v_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [rc4v_pkg::QPTR_W:0]   count_q, count_d;
  logic                        cls_valid;
  rc4v_pkg::op_e               cls_op;
  rc4v_pkg::cmd_t              cls_cmd;
  logic                        push;
  logic                        pop;

  // classify the mode, unknown mode is taken and dropped
  always_comb begin
    cls_valid = 1'b1;
    cls_op    = rc4v_pkg::OP_KEY;
    unique case (rc4v_pkg::mode_e'(s_mode_i))
      rc4v_pkg::MODE_KEY:    cls_op = rc4v_pkg::OP_KEY;
      rc4v_pkg::MODE_SCHED:  cls_op = rc4v_pkg::OP_SCHED;
      rc4v_pkg::MODE_CIPHER: cls_op = rc4v_pkg::OP_CIPHER;
      rc4v_pkg::MODE_NONE:   cls_valid = 1'b0;
    endcase
  end

  assign cls_cmd.op         = cls_op;
  assign cls_cmd.key_addr   = s_data_i[rc4v_pkg::KEY_AW-1:0];
  assign cls_cmd.byte_value = s_data_i[rc4v_pkg::KEY_AW +: rc4v_pkg::BYTE_W];

  // queue handshake
  assign s_ready_o   = (count_q != (rc4v_pkg::QPTR_W+1)'(rc4v_pkg::QUEUE_DEPTH));
  assign push        = s_valid_i && s_ready_o && cls_valid;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + rc4v_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + rc4v_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + {{rc4v_pkg::QPTR_W{1'b0}}, push}
                       - {{rc4v_pkg::QPTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

FILE: hw/rtl/rc4v_engine.sv
module rc4v_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rc4v_pkg::BYTE_W-1:0]  seed_i,
  input  logic                         cmd_valid_i,
  input  rc4v_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output rc4v_pkg::result_t            m_result_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_KS_RD_I = 9'b000000010,
    ST_KS_RD_J = 9'b000000100,
    ST_KS_WR_I = 9'b000001000,
    ST_KS_WR_J = 9'b000010000,
    ST_CI_RD_J = 9'b000100000,
    ST_CI_WR_I = 9'b001000000,
    ST_CI_WR_J = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_e;

  localparam int unsigned BW = rc4v_pkg::BYTE_W;
  localparam int unsigned KW = rc4v_pkg::KEY_AW;

  state_e state_q, state_d;

  // schedule registers
  logic [BW-1:0] step_q, step_d;
  logic [KW-1:0] kidx_q, kidx_d;
  logic [BW-1:0] roll_q, roll_d;
  logic [BW-1:0] sum_q, sum_d;
  logic [BW-1:0] accj_q, accj_d;
  logic [BW-1:0] k0_q, k0_d;
  logic          summing_q, summing_d;
  logic          ok_q, ok_d;

  // cipher registers
  logic [BW-1:0] i_q, i_d;
  logic [BW-1:0] j_q, j_d;
  logic [BW-1:0] tmp_q, tmp_d;
  logic [BW-1:0] b_q, b_d;
  logic [BW-1:0] data_q, data_d;
  logic          ti_q, ti_d;
  logic          tj_q, tj_d;

  // result and output register
  rc4v_pkg::result_t res_q, res_d;
  rc4v_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  // permutation memory with per-entry valid bits, invalid reads as identity
  logic [BW-1:0]         perm_mem [rc4v_pkg::PERM_DEPTH];
  logic [rc4v_pkg::PERM_DEPTH-1:0] pvld_q;
  logic                  perm_re, perm_we, perm_clr;
  logic [BW-1:0]         perm_raddr, perm_waddr, perm_wdata;
  logic [BW-1:0]         perm_rdata_q, prd_addr_q;
  logic                  prd_vld_q;
  logic [BW-1:0]         perm_rd;

  // key store, two registered read ports
  logic [BW-1:0] key_mem [rc4v_pkg::KEY_DEPTH];
  logic          key_we, key_re, key_in_range;
  logic [BW-1:0] key_rd0_q, key_rd1_q;
  logic [KW-1:0] kidx_nxt;

  // schedule step datapath
  logic [BW-1:0] roll_cur, roll_wrap, addend, sum_new, k0_eff, mix, acc_new;
  logic          wrap;

  // cipher datapath
  logic [BW-1:0] j_new, t_addr, ks;

  assign perm_rd      = prd_vld_q ? perm_rdata_q : prd_addr_q;
  assign key_in_range = (32'(cmd_i.key_addr) < rc4v_pkg::KEY_DEPTH);
  assign kidx_nxt     = kidx_q + KW'(1);

  assign roll_cur  = rc4v_pkg::rotr1(roll_q);
  assign roll_wrap = rc4v_pkg::rotr1(seed_i);
  assign wrap      = (roll_cur == key_rd0_q);
  assign addend    = {key_rd0_q[BW-2:0], 1'b0} + (roll_cur[0] ? key_rd0_q : '0);
  assign sum_new   = sum_q + addend;
  assign k0_eff    = (step_q == '0) ? key_rd0_q : k0_q;
  assign mix       = wrap ? (roll_wrap ^ k0_eff) : (roll_cur ^ key_rd0_q);
  assign acc_new   = mix + perm_rd + accj_q;

  assign j_new  = perm_rd + j_q;
  assign t_addr = tmp_q + perm_rd;
  assign ks     = tj_q ? tmp_q : (ti_q ? b_q : perm_rd);

  assign out_free   = !out_valid_q || m_ready_i;
  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    kidx_d      = kidx_q;
    roll_d      = roll_q;
    sum_d       = sum_q;
    accj_d      = accj_q;
    k0_d        = k0_q;
    summing_d   = summing_q;
    ok_d        = ok_q;
    i_d         = i_q;
    j_d         = j_q;
    tmp_d       = tmp_q;
    b_d         = b_q;
    data_d      = data_q;
    ti_d        = ti_q;
    tj_d        = tj_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    perm_re     = 1'b0;
    perm_raddr  = '0;
    perm_we     = 1'b0;
    perm_waddr  = '0;
    perm_wdata  = '0;
    perm_clr    = 1'b0;
    key_we      = 1'b0;
    key_re      = 1'b0;
    cmd_pop_o   = 1'b0;

    // drain the output register
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            rc4v_pkg::OP_KEY: begin
              key_we = key_in_range;
            end
            rc4v_pkg::OP_SCHED: begin
              perm_clr  = 1'b1;
              roll_d    = seed_i;
              sum_d     = seed_i;
              accj_d    = '0;
              kidx_d    = '0;
              summing_d = 1'b1;
              ok_d      = 1'b0;
              step_d    = '0;
              state_d   = ST_KS_RD_I;
            end
            rc4v_pkg::OP_CIPHER: begin
              i_d        = i_q + BW'(1);
              perm_re    = 1'b1;
              perm_raddr = i_q + BW'(1);
              data_d     = cmd_i.byte_value;
              state_d    = ST_CI_RD_J;
            end
            default: ;
          endcase
        end
      end
      // fetch perm[step] and the key bytes at the key index
      ST_KS_RD_I: begin
        perm_re    = 1'b1;
        perm_raddr = step_q;
        key_re     = 1'b1;
        state_d    = ST_KS_RD_J;
      end
      // rolling mask, key sum, new j and fetch perm[j]
      ST_KS_RD_J: begin
        if (summing_q) begin
          sum_d = sum_new;
        end
        if (wrap) begin
          if (summing_q) begin
            ok_d = (sum_new == key_rd1_q);
          end
          roll_d    = roll_wrap;
          kidx_d    = KW'(1);
          summing_d = 1'b0;
        end else begin
          roll_d = roll_cur;
          kidx_d = kidx_nxt;
        end
        if (step_q == '0) begin
          k0_d = key_rd0_q;
        end
        tmp_d      = perm_rd;
        accj_d     = acc_new;
        perm_re    = 1'b1;
        perm_raddr = acc_new;
        state_d    = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        perm_we    = 1'b1;
        perm_waddr = step_q;
        perm_wdata = perm_rd;
        state_d    = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = accj_q;
        perm_wdata = tmp_q;
        step_d     = step_q + BW'(1);
        if (step_q == '1) begin
          res_d   = '{kind: rc4v_pkg::KIND_SCHED, out_byte: '0, key_ok: ok_q};
          i_d     = '0;
          j_d     = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_KS_RD_I;
        end
      end
      // a = perm[i], new j, fetch perm[j]
      ST_CI_RD_J: begin
        tmp_d      = perm_rd;
        j_d        = j_new;
        perm_re    = 1'b1;
        perm_raddr = j_new;
        state_d    = ST_CI_WR_I;
      end
      // write perm[i] = b, fetch perm[a + b] and note forwarding cases
      ST_CI_WR_I: begin
        b_d        = perm_rd;
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rd;
        perm_re    = 1'b1;
        perm_raddr = t_addr;
        ti_d       = (t_addr == i_q);
        tj_d       = (t_addr == j_q);
        state_d    = ST_CI_WR_J;
      end
      ST_CI_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = tmp_q;
        res_d      = '{kind: rc4v_pkg::KIND_CIPHER, out_byte: data_q ^ ks, key_ok: 1'b0};
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    kidx_q    <= kidx_d;
    roll_q    <= roll_d;
    sum_q     <= sum_d;
    accj_q    <= accj_d;
    k0_q      <= k0_d;
    summing_q <= summing_d;
    ok_q      <= ok_d;
    tmp_q     <= tmp_d;
    b_q       <= b_d;
    data_q    <= data_d;
    ti_q      <= ti_d;
    tj_q      <= tj_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // permutation valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
    end else if (perm_clr) begin
      pvld_q <= '0;
    end else if (perm_we) begin
      pvld_q[perm_waddr] <= 1'b1;
    end
  end

  // permutation memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rdata_q <= perm_mem[perm_raddr];
      prd_vld_q    <= pvld_q[perm_raddr];
      prd_addr_q   <= perm_raddr;
    end
  end

  // key store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[cmd_i.key_addr] <= cmd_i.byte_value;
    end
    if (key_re) begin
      key_rd0_q <= key_mem[kidx_q];
      key_rd1_q <= key_mem[kidx_nxt];
    end
  end

endmodule

FILE: hw/rtl/rc4_variant_stream_cipher.sv
// RC4-style stream cipher with a modified key schedule. Items enter on the s_axis stream with
// the mode on tuser: key byte write, key schedule run, or cipher one data byte (mode 3 is taken
// and dropped). Results leave on m_axis with kind on tuser: one result per schedule run (kind 0,
// zero byte, key_ok flag) and one per data byte (kind 1, data XOR keystream). A four-entry
// command queue sits in front of the engine and a result register behind it, so input keeps
// flowing while a result waits. The permutation lives in a single-write-port memory and sets
// the pace: a key write is done at issue in the engine, a data byte runs read i, read j,
// write i with read of the keystream entry, write j and result load, and a schedule run
// has issue, 256 steps of read i, read j, write i, write j, and result load. Reset and each
// schedule run clear per-entry valid bits so the permutation reads as the identity at once; no
// clearing pass is needed. Unwritten key bytes read as undefined. The user must write the
// seed register through cfg_we_i/cfg_wdata_i only while the block is idle (not enforced).
`include "rc4_variant_stream_cipher_assert.svh"

module rc4_variant_stream_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rc4v_pkg::BYTE_W-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [rc4v_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // key_addr[8:0], byte_value[16:9]
  input  logic [rc4v_pkg::MODE_W-1:0]     s_axis_tuser_i,   // mode[1:0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [rc4v_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // out_byte[7:0], key_ok[8]
  output logic                            m_axis_tuser_o    // kind[0]
);

  logic [rc4v_pkg::BYTE_W-1:0] seed_q;
  logic                        cmd_valid;
  logic                        cmd_pop;
  rc4v_pkg::cmd_t              cmd;
  rc4v_pkg::result_t           result;
  logic                        out_cipher;
  logic                        out_sched;

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // accept, classify and queue
  rc4v_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_mode_i    (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // key schedule and keystream engine
  rc4v_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_result_o  (result)
  );

  // output packing
  assign m_axis_tdata_o = {{(rc4v_pkg::OUT_DATA_W - rc4v_pkg::BYTE_W - 1){1'b0}},
                           result.key_ok, result.out_byte};
  assign m_axis_tuser_o = result.kind;

  // result kind on offer
  assign out_cipher = m_axis_tvalid_o && (m_axis_tuser_o == rc4v_pkg::KIND_CIPHER);
  assign out_sched  = m_axis_tvalid_o && (m_axis_tuser_o == rc4v_pkg::KIND_SCHED);

  // engine takes a transaction only from a filled queue
  `RC4V_ASSERT_IMP(a_pop_from_filled, cmd_pop, cmd_valid)

  // schedule and cipher work keep the engine busy past the pop that takes them
  `RC4V_ASSERT_NXT(a_busy_after_pop, cmd_pop && (cmd.op != rc4v_pkg::OP_KEY), !cmd_pop)

  // cipher results never carry the key check flag
  `RC4V_ASSERT_IMP(a_cipher_no_flag, out_cipher, m_axis_tdata_o[rc4v_pkg::BYTE_W] == 1'b0)

  // schedule results carry a zero byte
  `RC4V_ASSERT_IMP(a_sched_zero_byte, out_sched, m_axis_tdata_o[rc4v_pkg::BYTE_W-1:0] == '0)

endmodule

FILE: sim/rc4_variant_stream_cipher_test.sv
module rc4_variant_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    rc4v_pkg::mode_e                     mode;
    logic [rc4v_pkg::KEY_AW-1:0] key_addr;
    logic [rc4v_pkg::BYTE_W-1:0] byte_value;
  } cipher_item_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rc4v_pkg::BYTE_W-1:0]     cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rc4v_pkg::IN_DATA_W-1:0]  s_tdata = '0;     // key_addr[8:0], byte_value[16:9]
  logic [rc4v_pkg::MODE_W-1:0]     s_tuser = '0;     // mode[1:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [rc4v_pkg::OUT_DATA_W-1:0] m_tdata;          // out_byte[7:0], key_ok[8]
  logic                            m_tuser;          // kind[0]

  // stimulus side
  cipher_item_t                stream_items[$];
  int unsigned                 queued_items = 0;
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_stall_pct = 0;
  logic [rc4v_pkg::BYTE_W-1:0] gen_seed = '0;

  // cipher state as the testbench sees it
  logic [rc4v_pkg::BYTE_W-1:0] perm_model[rc4v_pkg::PERM_DEPTH];
  logic [rc4v_pkg::BYTE_W-1:0] key_model[rc4v_pkg::KEY_DEPTH];
  logic [rc4v_pkg::BYTE_W-1:0] ks_i = '0;
  logic [rc4v_pkg::BYTE_W-1:0] ks_j = '0;
  logic [rc4v_pkg::BYTE_W-1:0] seed_model = '0;
  rc4v_pkg::result_t           awaited_outputs[$];

  int unsigned failures = 0;
  int unsigned cycles = 0;

  rc4_variant_stream_cipher uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [rc4v_pkg::BYTE_W-1:0] rot_right(
    input logic [rc4v_pkg::BYTE_W-1:0] v
  );
    return {v[0], v[rc4v_pkg::BYTE_W-1:1]};
  endfunction

  // rebuild the permutation from the key store, returns the key check flag
  function automatic logic run_key_schedule();
    logic [rc4v_pkg::BYTE_W-1:0] roll, sum, acc, kb, mix, tmp;
    int unsigned kidx;
    logic summing, ok;
    roll = seed_model;
    sum = seed_model;
    acc = '0;
    kidx = 0;
    summing = 1'b1;
    ok = 1'b0;
    for (int t = 0; t < rc4v_pkg::PERM_DEPTH; t++) perm_model[t] = rc4v_pkg::BYTE_W'(t);
    for (int step = 0; step < rc4v_pkg::PERM_DEPTH; step++) begin
      roll = rot_right(roll);
      kb = key_model[kidx];
      if (summing) sum = sum + kb * (roll[0] ? 8'd3 : 8'd2);
      mix = roll ^ kb;
      // rolling byte hit the key byte: restart the key index
      if (roll == kb) begin
        if (summing) ok = (sum == key_model[kidx + 1]);
        roll = rot_right(seed_model);
        kidx = 0;
        summing = 1'b0;
        mix = roll ^ key_model[0];
      end
      tmp = perm_model[step];
      acc = mix + tmp + acc;
      perm_model[step] = perm_model[acc];
      perm_model[acc] = tmp;
      kidx++;
    end
    ks_i = '0;
    ks_j = '0;
    return ok;
  endfunction

  // one keystream step applied to a data byte
  function automatic logic [rc4v_pkg::BYTE_W-1:0] keystream_xor(
    input logic [rc4v_pkg::BYTE_W-1:0] data
  );
    logic [rc4v_pkg::BYTE_W-1:0] a, b, ks_idx;
    ks_i = ks_i + 8'd1;
    a = perm_model[ks_i];
    ks_j = a + ks_j;
    b = perm_model[ks_j];
    perm_model[ks_i] = b;
    perm_model[ks_j] = a;
    ks_idx = a + b;
    return data ^ perm_model[ks_idx];
  endfunction

  function automatic void queue_item(rc4v_pkg::mode_e m, logic [rc4v_pkg::KEY_AW-1:0] a,
                                     logic [rc4v_pkg::BYTE_W-1:0] v);
    cipher_item_t it;
    it.mode = m;
    it.key_addr = a;
    it.byte_value = v;
    stream_items.push_back(it);
    if (m != rc4v_pkg::MODE_NONE) queued_items++;
  endfunction

  function automatic void queue_data(int unsigned n);
    for (int k = 0; k < n; k++)
      queue_item(rc4v_pkg::MODE_CIPHER, rc4v_pkg::KEY_AW'($urandom),
                 rc4v_pkg::BYTE_W'($urandom));
  endfunction

  function automatic void queue_key_writes(int unsigned n);
    for (int k = 0; k < n; k++)
      queue_item(rc4v_pkg::MODE_KEY,
                 rc4v_pkg::KEY_AW'($urandom_range(rc4v_pkg::KEY_DEPTH - 1)),
                 rc4v_pkg::BYTE_W'($urandom));
  endfunction

  // key bytes that force the first index wrap at step p, check byte right or wrong
  function automatic void queue_wrap_key(int unsigned p, bit match);
    logic [rc4v_pkg::BYTE_W-1:0] roll, sum, kb;
    roll = gen_seed;
    sum = gen_seed;
    for (int unsigned t = 0; t <= p; t++) begin
      roll = rot_right(roll);
      kb = (t == p) ? roll : roll ^ rc4v_pkg::BYTE_W'($urandom_range(1, 255));
      sum = sum + kb * (roll[0] ? 8'd3 : 8'd2);
      queue_item(rc4v_pkg::MODE_KEY, rc4v_pkg::KEY_AW'(t), kb);
    end
    queue_item(rc4v_pkg::MODE_KEY, rc4v_pkg::KEY_AW'(p + 1),
               match ? sum : sum ^ rc4v_pkg::BYTE_W'($urandom_range(1, 255)));
  endfunction

  function automatic void queue_random_traffic(int unsigned target);
    int unsigned start, pick;
    start = queued_items;
    while (queued_items - start < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // new key, schedule, then a burst of data
        queue_wrap_key($urandom_range(0, 12), $urandom_range(0, 2) != 0);
        if ($urandom_range(1) != 0) queue_key_writes($urandom_range(1, 4));
        queue_item(rc4v_pkg::MODE_SCHED, rc4v_pkg::KEY_AW'($urandom),
                   rc4v_pkg::BYTE_W'($urandom));
        queue_data($urandom_range(1, 24));
      end else if (pick < 70) begin
        queue_data($urandom_range(1, 16));
      end else if (pick < 85) begin
        queue_key_writes($urandom_range(1, 6));
      end else if (pick < 92) begin
        for (int k = 0; k < 1 + $urandom_range(2); k++)
          queue_item(rc4v_pkg::MODE_NONE, rc4v_pkg::KEY_AW'($urandom),
                     rc4v_pkg::BYTE_W'($urandom));
      end else begin
        queue_item(rc4v_pkg::MODE_SCHED, rc4v_pkg::KEY_AW'($urandom),
                   rc4v_pkg::BYTE_W'($urandom));
        queue_data($urandom_range(1, 8));
      end
    end
  endfunction

  // let the sender go quiet until every awaited result is back
  task automatic wait_idle();
    while (stream_items.size() != 0 || s_tvalid || awaited_outputs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [rc4v_pkg::BYTE_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    seed_model = v;
    gen_seed = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // model reset state
  initial begin
    for (int t = 0; t < rc4v_pkg::PERM_DEPTH; t++) perm_model[t] = rc4v_pkg::BYTE_W'(t);
    for (int t = 0; t < rc4v_pkg::KEY_DEPTH; t++) key_model[t] = '0;
  end

  // input driver, models each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_item_t      nxt;
    rc4v_pkg::result_t exp_item;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        case (rc4v_pkg::mode_e'(s_tuser))
          rc4v_pkg::MODE_KEY: begin
            key_model[s_tdata[8:0]] = s_tdata[16:9];
          end
          rc4v_pkg::MODE_SCHED: begin
            exp_item.kind     = rc4v_pkg::KIND_SCHED;
            exp_item.out_byte = 8'd0;
            exp_item.key_ok   = run_key_schedule();
            awaited_outputs.push_back(exp_item);
          end
          rc4v_pkg::MODE_CIPHER: begin
            exp_item.kind     = rc4v_pkg::KIND_CIPHER;
            exp_item.out_byte = keystream_xor(s_tdata[16:9]);
            exp_item.key_ok   = 1'b0;
            awaited_outputs.push_back(exp_item);
          end
          default: ;
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = stream_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, nxt.byte_value, nxt.key_addr};
          s_tuser <= nxt.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    rc4v_pkg::result_t exp_res;
    if (rst_ni && m_tvalid && m_tready) begin
      if (awaited_outputs.size() == 0) begin
        $error("result transaction with nothing awaited: kind %0d out_byte %02h key_ok %0d",
               m_tuser, m_tdata[7:0], m_tdata[8]);
        failures++;
      end else begin
        exp_res = awaited_outputs.pop_front();
        if (m_tuser !== exp_res.kind) begin
          $error("kind: expected %0d, got %0d", exp_res.kind, m_tuser);
          failures++;
        end
        if (m_tdata[7:0] !== exp_res.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp_res.out_byte, m_tdata[7:0]);
          failures++;
        end
        if (m_tdata[8] !== exp_res.key_ok) begin
          $error("key_ok: expected %0d, got %0d", exp_res.key_ok, m_tdata[8]);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rc4_variant_stream_cipher test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_seed(8'h00);

    // data before any schedule runs on the identity permutation
    queue_item(rc4v_pkg::MODE_CIPHER, '0, 8'h00);
    queue_item(rc4v_pkg::MODE_CIPHER, '1, 8'hFF);
    queue_item(rc4v_pkg::MODE_NONE, '1, 8'hFF);
    queue_item(rc4v_pkg::MODE_KEY, 9'd511, 8'hFF);
    wait_idle();

    // fill the readable key range with random nonzero bytes, which may still match the rolling byte
    for (int t = 0; t <= rc4v_pkg::PERM_DEPTH; t++)
      queue_item(rc4v_pkg::MODE_KEY, rc4v_pkg::KEY_AW'(t),
                 rc4v_pkg::BYTE_W'($urandom_range(1, 255)));
    queue_item(rc4v_pkg::MODE_SCHED, '0, '0);
    queue_data(2);
    // wrap on the first step with a good check byte
    queue_wrap_key(0, 1'b1);
    queue_item(rc4v_pkg::MODE_SCHED, '1, '1);
    queue_item(rc4v_pkg::MODE_CIPHER, '0, 8'h00);
    queue_item(rc4v_pkg::MODE_CIPHER, '0, 8'hFF);
    queue_item(rc4v_pkg::MODE_CIPHER, '0, 8'hA5);
    // wrap with a bad check byte
    queue_wrap_key(3, 1'b0);
    queue_item(rc4v_pkg::MODE_SCHED, '0, '0);
    queue_data(2);
    // wrap on the last step, check byte sits past the permutation size
    queue_wrap_key(rc4v_pkg::PERM_DEPTH - 1, 1'b1);
    queue_item(rc4v_pkg::MODE_SCHED, '0, '0);
    queue_data(3);
    wait_idle();

    // phase 0: no idling
    queue_random_traffic(PHASE_ITEMS);
    wait_idle();

    // phase 1: sender idles
    write_seed(8'hFF);
    send_idle_pct = 57;
    recv_stall_pct = 0;
    queue_random_traffic(PHASE_ITEMS);
    wait_idle();

    // phase 2: receiver stalls
    write_seed(rc4v_pkg::BYTE_W'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_stall_pct = 57;
    queue_random_traffic(PHASE_ITEMS);
    wait_idle();

    // phase 3: both sides idle
    write_seed(8'h80);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    queue_random_traffic(PHASE_ITEMS);
    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (awaited_outputs.size() != 0) begin
      $error("%0d results never arrived", awaited_outputs.size());
      failures++;
    end
    if (failures == 0) begin
      $display("rc4_variant_stream_cipher test passed");
    end else begin
      $display("rc4_variant_stream_cipher test failed");
    end
    $finish;
  end

endmodule

FILE: rc4_variant_stream_cipher.f
+incdir+hw/rtl
hw/rtl/rc4v_pkg.sv
hw/rtl/rc4v_front.sv
hw/rtl/rc4v_engine.sv
hw/rtl/rc4_variant_stream_cipher.sv
sim/rc4_variant_stream_cipher_test.sv
